/* sv/ptb_pkg.sv */
// Package for the palette tone blender: shared types and constants.
// No dependencies; used by every module of the block.
package ptb_pkg;

    // Tone range and blend constants
    localparam logic [7:0] TONE_MAX     = 8'd200;
    localparam logic [7:0] TONE_NEUTRAL = 8'd100;
    localparam logic [3:0] COMP_MAX     = 4'd15;

    // x / 100 for x <= 1500 as (x * 1311) >> 17
    localparam logic [21:0] RECIP_100   = 22'd1311;
    localparam int          RECIP_SHIFT = 17;

    // Register indexes on the configuration port
    localparam logic [1:0] REG_RED   = 2'd0;
    localparam logic [1:0] REG_GREEN = 2'd1;
    localparam logic [1:0] REG_BLUE  = 2'd2;

    localparam int CFG_ADDR_W = 5;

    // Classified tone request, one queue entry
    typedef struct packed {
        logic [7:0] tone;   // clamped tone
        logic       up;     // blend toward white
        logic [6:0] delta;  // distance from neutral, 0..100
    } t_tone_cmd;

    // One blended palette entry
    typedef struct packed {
        logic       last;
        logic [7:0] tone;
        logic [3:0] blue;
        logic [3:0] green;
        logic [3:0] red;
        logic [3:0] color;
    } t_pixel;

endpackage

/* sv/ptb_front.sv */
// Front end of the palette tone blender: accepts tone beats and classifies them.
// Depends on ptb_pkg.
module ptb_front (
    input  logic                  i_valid,
    input  logic signed [9:0]     i_tone,
    input  logic                  i_q_full,
    output logic                  o_ready,
    output logic                  o_push,
    output ptb_pkg::t_tone_cmd    o_cmd
);
    import ptb_pkg::*;

    logic [7:0] w_tone;

    // Clamp to 0..200
    always_comb begin
        if (i_tone < 10'sd0) begin
            w_tone = 8'd0;
        end else if (i_tone > $signed({2'b00, TONE_MAX})) begin
            w_tone = TONE_MAX;
        end else begin
            w_tone = i_tone[7:0];
        end
    end

    // Direction and distance from neutral
    always_comb begin
        o_cmd.tone = w_tone;
        o_cmd.up   = (w_tone > TONE_NEUTRAL);
        if (w_tone > TONE_NEUTRAL) begin
            o_cmd.delta = 7'(w_tone - TONE_NEUTRAL);
        end else begin
            o_cmd.delta = 7'(TONE_NEUTRAL - w_tone);
        end
    end

    assign o_ready = !i_q_full;
    assign o_push  = i_valid && !i_q_full;

endmodule

/* sv/ptb_queue.sv */
// Two-entry queue of classified tone requests between front and back end.
// Depends on ptb_pkg.
module ptb_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  ptb_pkg::t_tone_cmd    i_cmd,
    input  logic                  i_pop,
    output logic                  o_full,
    output logic                  o_valid,
    output ptb_pkg::t_tone_cmd    o_cmd
);
    import ptb_pkg::*;

    t_tone_cmd  r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    logic       w_push;
    logic       w_pop;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    // Storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            r_count <= 2'(r_count + {1'b0, w_push} - {1'b0, w_pop});
        end
    end

endmodule

/* sv/ptb_back.sv */
// Back end of the palette tone blender: walks the colors of one request and
// blends them in a two-stage pipeline. Depends on ptb_pkg.
module ptb_back #(
    parameter int COLOR_ENTRIES = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_q_valid,
    input  ptb_pkg::t_tone_cmd    i_cmd,
    output logic                  o_pop,
    input  logic [63:0]           i_src_red,
    input  logic [63:0]           i_src_green,
    input  logic [63:0]           i_src_blue,
    output logic                  o_valid,
    input  logic                  i_ready,
    output ptb_pkg::t_pixel       o_pixel
);
    import ptb_pkg::*;

    localparam logic [3:0] COLOR_LAST = 4'(COLOR_ENTRIES - 1);

    // Issue counter
    logic [3:0]  r_color;
    logic        w_adv;
    logic        w_issue;

    // Stage 1: source components and scaled products
    logic        r_s1_valid;
    logic [3:0]  r_s1_color;
    t_tone_cmd   r_s1_cmd;
    logic [3:0]  r_s1_v    [3];
    logic [10:0] r_s1_prod [3];

    // Output register
    logic        r_out_valid;
    t_pixel      r_out;

    logic [3:0]  w_v    [3];
    logic [10:0] w_prod [3];
    logic [3:0]  w_res  [3];

    // Whole pipeline moves when the output slot frees up
    assign w_adv   = !r_out_valid || i_ready;
    assign w_issue = w_adv && i_q_valid;
    assign o_pop   = w_issue && (r_color == COLOR_LAST);

    // Component select for the color being issued
    assign w_v[0] = i_src_red[{r_color, 2'b00} +: 4];
    assign w_v[1] = i_src_green[{r_color, 2'b00} +: 4];
    assign w_v[2] = i_src_blue[{r_color, 2'b00} +: 4];

    // Distance to the target times tone offset
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            if (i_cmd.up) begin
                w_prod[k] = 11'(COMP_MAX - w_v[k]) * 11'(i_cmd.delta);
            end else begin
                w_prod[k] = 11'(w_v[k]) * 11'(i_cmd.delta);
            end
        end
    end

    // Divide by 100 and apply toward white or black
    always_comb begin
        logic [21:0] p;
        logic [3:0]  q;
        for (int k = 0; k < 3; k++) begin
            p = 22'(r_s1_prod[k]) * RECIP_100;
            q = p[RECIP_SHIFT +: 4];
            if (r_s1_cmd.up) begin
                w_res[k] = r_s1_v[k] + q;
            end else begin
                w_res[k] = r_s1_v[k] - q;
            end
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_color     <= 4'd1;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_s1_valid  <= i_q_valid;
            r_out_valid <= r_s1_valid;
            if (w_issue) begin
                r_color <= (r_color == COLOR_LAST) ? 4'd1 : 4'(r_color + 4'd1);
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1_color <= r_color;
            r_s1_cmd   <= i_cmd;
            for (int k = 0; k < 3; k++) begin
                r_s1_v[k]    <= w_v[k];
                r_s1_prod[k] <= w_prod[k];
            end
            r_out.color <= r_s1_color;
            r_out.red   <= w_res[0];
            r_out.green <= w_res[1];
            r_out.blue  <= w_res[2];
            r_out.tone  <= r_s1_cmd.tone;
            r_out.last  <= (r_s1_color == COLOR_LAST);
        end
    end

    assign o_valid = r_out_valid;
    assign o_pixel = r_out;

    // Counter stays within colors 1..COLOR_ENTRIES-1
    a_color_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_color != 4'd0) && (r_color <= COLOR_LAST))
        else $error("color counter out of range");

    // Queue entry is released only on the last color
    a_pop_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> (r_color == COLOR_LAST) && i_q_valid)
        else $error("request released early");

    // After the last color the counter restarts at color 1
    a_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_color == 4'd1))
        else $error("color counter did not wrap");

    // A stalled stage-1 entry is not dropped
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !w_adv) |=> r_s1_valid)
        else $error("stage 1 entry lost on stall");

endmodule

/* sv/palette_tone_blender.sv */
// Palette tone blender top level: APB palette registers, front end, queue, back end.
// First result of a request: queue, then stage-1 register, then output register.
// One color per cycle unless the output stalls, COLOR_ENTRIES-1 colors per request
// (15 by default); the queue holds the request in progress and one waiting request.
// Reset (synchronous, active low) empties the pipeline and clears the palette.
module palette_tone_blender #(
    parameter int COLOR_ENTRIES = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // APB configuration port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [ptb_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [63:0]                     pwdata,
    output logic [63:0]                     prdata,
    output logic                            pready,
    // Tone requests
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [15:0]                     s_axis_tdata,  // [9:0] tone_request
    // Blended palette entries
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [23:0]                     m_axis_tdata,  // color_index, red_out,
                                                           // green_out, blue_out,
                                                           // applied_tone
    output logic                            m_axis_tlast   // last_entry
);
    import ptb_pkg::*;

    logic [63:0] r_src_red;
    logic [63:0] r_src_green;
    logic [63:0] r_src_blue;

    logic        w_wr;
    logic [1:0]  w_reg_idx;

    logic        w_q_full;
    logic        w_push;
    t_tone_cmd   w_push_cmd;
    logic        w_q_valid;
    t_tone_cmd   w_head_cmd;
    logic        w_pop;
    t_pixel      w_pixel;

    // Configuration registers
    assign pready    = 1'b1;
    assign w_wr      = psel && penable && pwrite;
    assign w_reg_idx = paddr[4:3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_red   <= '0;
            r_src_green <= '0;
            r_src_blue  <= '0;
        end else if (w_wr) begin
            unique case (w_reg_idx)
                REG_RED:   r_src_red   <= pwdata;
                REG_GREEN: r_src_green <= pwdata;
                REG_BLUE:  r_src_blue  <= pwdata;
                default:   ;
            endcase
        end
    end

    always_comb begin
        unique case (w_reg_idx)
            REG_RED:   prdata = r_src_red;
            REG_GREEN: prdata = r_src_green;
            REG_BLUE:  prdata = r_src_blue;
            default:   prdata = '0;
        endcase
    end

    ptb_front u_front (
        .i_valid  (s_axis_tvalid),
        .i_tone   ($signed(s_axis_tdata[9:0])),
        .i_q_full (w_q_full),
        .o_ready  (s_axis_tready),
        .o_push   (w_push),
        .o_cmd    (w_push_cmd)
    );

    ptb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .i_pop   (w_pop),
        .o_full  (w_q_full),
        .o_valid (w_q_valid),
        .o_cmd   (w_head_cmd)
    );

    ptb_back #(
        .COLOR_ENTRIES (COLOR_ENTRIES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (w_q_valid),
        .i_cmd       (w_head_cmd),
        .o_pop       (w_pop),
        .i_src_red   (r_src_red),
        .i_src_green (r_src_green),
        .i_src_blue  (r_src_blue),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_pixel     (w_pixel)
    );

    assign m_axis_tdata = {w_pixel.tone, w_pixel.blue, w_pixel.green,
                           w_pixel.red, w_pixel.color};
    assign m_axis_tlast = w_pixel.last;

endmodule

/* tb/palette_tone_blender_test.sv */
// Self-checking testbench for palette_tone_blender: APB palette loads, tone beats in,
// blended palette entries out, each checked against an in-bench fade predictor.
// Depends on ptb_pkg and palette_tone_blender only.
`timescale 1ns / 1ps

module palette_tone_blender_test;
    import ptb_pkg::*;

    localparam int ENTRIES       = 16;
    localparam int IDLE_LIMIT    = 5000;   // cycles with no beat anywhere
    localparam int LONG_HOLD     = 300;    // receiver hold-off, in cycles
    localparam int TAIL_CYCLES   = 30;
    localparam int PHASE_TONES   = 96;
    localparam int REPORT_MAX    = 10;
    localparam logic [1:0] REG_UNUSED = 2'd3;  // no register behind this index

    typedef enum {ROW_TONE, ROW_PALETTE, ROW_BAD_REG} t_row_kind;

    // One row of the directed stimulus table
    typedef struct {
        t_row_kind   kind;
        logic [9:0]  tone;
        bit          fixed;      // expectation typed in below
        logic [3:0]  fix_comp;   // every component of every entry
        logic [7:0]  fix_tone;
        logic [63:0] red;
        logic [63:0] green;
        logic [63:0] blue;
    } t_row;

    // Clock and reset
    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    // Block inputs, known from time zero
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [63:0]           pwdata = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic [15:0]           s_axis_tdata = '0;
    logic                  m_axis_tready = 1'b0;

    // Block outputs
    logic [63:0] prdata;
    logic        pready;
    logic        s_axis_tready;
    logic        m_axis_tvalid;
    logic [23:0] m_axis_tdata;
    logic        m_axis_tlast;

    // Shadow palette and pending blended entries
    logic [63:0] pal_red = '0;
    logic [63:0] pal_green = '0;
    logic [63:0] pal_blue = '0;
    t_pixel      pending_entries[$];

    // Run bookkeeping
    int  mismatches = 0;
    int  tones_sent = 0;
    int  entries_seen = 0;
    int  palettes_loaded = 0;
    int  idle_cycles = 0;
    int  hold_req = 0;
    int  hold_left = 0;
    bit  tx_burst = 1'b0;
    bit  rx_burst = 1'b0;

    palette_tone_blender #(
        .COLOR_ENTRIES(ENTRIES)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // [9:0] tone_request
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // [3:0] color, [7:4] red, [11:8] green,
                                         // [15:12] blue, [23:16] tone
        .m_axis_tlast  (m_axis_tlast)    // last entry of the run
    );

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Sign-extend the request and clamp to 0..200
    function automatic logic [7:0] clamp_tone(logic [9:0] raw);
        logic signed [9:0] sreq;
        int req;
        sreq = raw;
        req = sreq;
        if (req < 0) return 8'd0;
        if (req > int'(TONE_MAX)) return TONE_MAX;
        return req[7:0];
    endfunction

    // Fade one 4-bit component toward white or black
    function automatic logic [3:0] fade_comp(logic [3:0] comp, logic [7:0] tone);
        int v;
        int t;
        int r;
        v = comp;
        t = tone;
        if (t > int'(TONE_NEUTRAL))
            r = v + ((int'(COMP_MAX) - v) * (t - int'(TONE_NEUTRAL))) / int'(TONE_NEUTRAL);
        else
            r = v - (v * (int'(TONE_NEUTRAL) - t)) / int'(TONE_NEUTRAL);
        return r[3:0];
    endfunction

    function automatic t_pixel faded_entry(int color, logic [7:0] tone);
        t_pixel px;
        px.color = color[3:0];
        px.red   = fade_comp(pal_red[4*color +: 4], tone);
        px.green = fade_comp(pal_green[4*color +: 4], tone);
        px.blue  = fade_comp(pal_blue[4*color +: 4], tone);
        px.tone  = tone;
        px.last  = (color == ENTRIES - 1);
        return px;
    endfunction

    // Queue the whole run of entries one tone beat causes
    task automatic queue_fade_run(logic [9:0] raw, bit fixed, logic [3:0] fc, logic [7:0] ft);
        t_pixel px;
        for (int c = 1; c < ENTRIES; c++) begin
            if (fixed) begin
                px.color = c[3:0];
                px.red   = fc;
                px.green = fc;
                px.blue  = fc;
                px.tone  = ft;
                px.last  = (c == ENTRIES - 1);
            end else begin
                px = faded_entry(c, clamp_tone(raw));
            end
            pending_entries.push_back(px);
        end
    endtask

    task automatic note_mismatch(string msg);
        if (mismatches < REPORT_MAX) $display("MISMATCH at %0t: %s", $realtime, msg);
        mismatches++;
    endtask

    // Compare one output beat with the oldest pending entry
    task automatic check_entry(t_pixel got);
        t_pixel want;
        if (pending_entries.size() == 0) begin
            note_mismatch($sformatf("entry with nothing pending: color %0d rgb %h%h%h tone %0d last %0b",
                got.color, got.red, got.green, got.blue, got.tone, got.last));
        end else begin
            want = pending_entries.pop_front();
            if (got.color !== want.color || got.red !== want.red || got.green !== want.green ||
                got.blue !== want.blue || got.tone !== want.tone || got.last !== want.last)
                note_mismatch($sformatf(
                    "expected color %0d rgb %h%h%h tone %0d last %0b, got color %0d rgb %h%h%h tone %0d last %0b",
                    want.color, want.red, want.green, want.blue, want.tone, want.last,
                    got.color, got.red, got.green, got.blue, got.tone, got.last));
        end
    endtask

    // Gap length: mostly none, some short, a few long
    function automatic int pick_gap(bit burst);
        int r;
        if (burst) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Receiver: take output beats, check them, pace tready
    always @(posedge i_clk) begin
        t_pixel got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.color = m_axis_tdata[3:0];
            got.red   = m_axis_tdata[7:4];
            got.green = m_axis_tdata[11:8];
            got.blue  = m_axis_tdata[15:12];
            got.tone  = m_axis_tdata[23:16];
            got.last  = m_axis_tlast;
            entries_seen++;
            check_entry(got);
        end
        if (hold_req > 0) begin
            hold_left = hold_req;
            hold_req = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else if (!rx_burst && $urandom_range(0, 99) < 15) begin
            hold_left = pick_gap(1'b0);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Watchdog on cycles with no beat anywhere
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout after %0d idle cycles, %0d entries pending",
                idle_cycles, pending_entries.size());
            $display("simulation failed");
            $finish;
        end
    end

    // One APB transfer: setup cycle, then access until pready
    task automatic apb_xfer(logic wr, logic [1:0] idx, logic [63:0] wdata,
                            output logic [63:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 3'b000};
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // Write a palette register, mirror it, read it back
    task automatic write_palette_reg(logic [1:0] idx, logic [63:0] value);
        logic [63:0] rd;
        apb_xfer(1'b1, idx, value, rd);
        case (idx)
            REG_RED:   pal_red = value;
            REG_GREEN: pal_green = value;
            REG_BLUE:  pal_blue = value;
            default: ;
        endcase
        apb_xfer(1'b0, idx, '0, rd);
        if (rd !== value)
            note_mismatch($sformatf("register %0d read back %h, wrote %h", idx, rd, value));
    endtask

    // Hold the input low until every pending entry has come out
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_entries.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic load_palette(logic [63:0] r, logic [63:0] g, logic [63:0] b);
        wait_drained();
        write_palette_reg(REG_RED, r);
        write_palette_reg(REG_GREEN, g);
        write_palette_reg(REG_BLUE, b);
        palettes_loaded++;
    endtask

    // Offer one tone beat, queue its entries on acceptance, then idle for the requested gap
    task automatic send_tone(logic [9:0] raw, int gap, bit fixed = 1'b0,
                             logic [3:0] fc = '0, logic [7:0] ft = '0);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'b0, raw};
        do @(posedge i_clk); while (!(s_axis_tvalid && s_axis_tready));
        queue_fade_run(raw, fixed, fc, ft);
        tones_sent++;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    function automatic logic [9:0] random_tone();
        logic [9:0] picks[9];
        int sel;
        picks = '{10'd0, 10'd100, 10'd200, 10'h3FF, 10'h200, 10'h1FF, 10'd201, 10'd99, 10'd101};
        sel = $urandom_range(0, 9);
        if (sel == 0) return 10'($urandom);
        if (sel == 1) return picks[$urandom_range(0, 8)];
        return 10'($urandom_range(0, 200));
    endfunction

    function automatic t_row row_tone(logic [9:0] tone, bit fixed = 1'b0,
                                      logic [3:0] fc = '0, logic [7:0] ft = '0);
        return '{ROW_TONE, tone, fixed, fc, ft, 64'd0, 64'd0, 64'd0};
    endfunction

    function automatic t_row row_palette(t_row_kind kind, logic [63:0] r,
                                         logic [63:0] g = '0, logic [63:0] b = '0);
        return '{kind, 10'd0, 1'b0, 4'd0, 8'd0, r, g, b};
    endfunction

    // Stimulus
    initial begin
        t_row rows[$];
        logic [63:0] rd;

        // Directed table: reset palette, clamps, extremes, neutral and near-neutral tones
        rows.push_back(row_tone(10'd100, 1'b1, 4'h0, 8'd100));
        rows.push_back(row_tone(10'h200, 1'b1, 4'h0, 8'd0));    // most negative request
        rows.push_back(row_tone(10'h1FF, 1'b1, 4'hF, 8'd200));  // largest request
        rows.push_back(row_palette(ROW_PALETTE, 64'hFEDC_BA98_7654_3210,
                                   64'h0123_4567_89AB_CDEF, 64'h5A5A_5A5A_C3C3_C3C3));
        rows.push_back(row_tone(10'd0, 1'b1, 4'h0, 8'd0));
        rows.push_back(row_tone(10'd200, 1'b1, 4'hF, 8'd200));
        rows.push_back(row_tone(10'd201, 1'b1, 4'hF, 8'd200));  // just above white
        rows.push_back(row_tone(10'h3FF, 1'b1, 4'h0, 8'd0));    // minus one
        rows.push_back(row_tone(10'd100));
        rows.push_back(row_tone(10'd101));
        rows.push_back(row_tone(10'd99));
        rows.push_back(row_tone(10'd150));
        rows.push_back(row_tone(10'd50));
        rows.push_back(row_tone(10'd1));
        rows.push_back(row_tone(10'd199));
        rows.push_back(row_palette(ROW_PALETTE, 64'hFFFF_FFFF_FFFF_FFFF, 64'd0,
                                   64'hAAAA_AAAA_AAAA_AAAA));
        rows.push_back(row_tone(10'd100));
        rows.push_back(row_tone(10'd175));
        rows.push_back(row_tone(10'd25));
        // write past the last register must leave the palette alone
        rows.push_back(row_palette(ROW_BAD_REG, 64'h0F1E_2D3C_4B5A_6978));
        rows.push_back(row_tone(10'd123));
        rows.push_back(row_tone(10'd77));

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[i]) begin
            case (rows[i].kind)
                ROW_TONE:
                    send_tone(rows[i].tone, pick_gap(1'b0), rows[i].fixed,
                              rows[i].fix_comp, rows[i].fix_tone);
                ROW_PALETTE:
                    load_palette(rows[i].red, rows[i].green, rows[i].blue);
                ROW_BAD_REG: begin
                    wait_drained();
                    apb_xfer(1'b1, REG_UNUSED, rows[i].red, rd);
                end
                default: ;
            endcase
        end

        // Random phases, each on its own palette
        for (int p = 0; p < 5; p++) begin
            case (p)
                0: load_palette({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom});
                1: load_palette(64'd0, 64'd0, 64'd0);
                2: load_palette(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
                                64'hFFFF_FFFF_FFFF_FFFF);
                default:
                    load_palette({$urandom, $urandom}, {$urandom, $urandom},
                                 {$urandom, $urandom});
            endcase
            tx_burst = (p == 0);
            rx_burst = (p == 0);
            // long receiver hold-off while the sender keeps pushing
            if (p == 1) hold_req = LONG_HOLD;
            for (int i = 0; i < PHASE_TONES; i++)
                send_tone(random_tone(), pick_gap(tx_burst || (p == 1 && i < 8)));
        end
        tx_burst = 1'b0;
        rx_burst = 1'b0;

        // Drain, then a quiet tail to catch stray beats
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (pending_entries.size() != 0)
            note_mismatch($sformatf("%0d entries never came out", pending_entries.size()));

        $display("Covered %0d tone beats over %0d palettes, %0d blended entries checked.",
                 tones_sent, palettes_loaded, entries_seen);
        $display("Mismatches: %0d", mismatches);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

/* filelist.f */
sv/ptb_pkg.sv
sv/ptb_front.sv
sv/ptb_queue.sv
sv/ptb_back.sv
sv/palette_tone_blender.sv
tb/palette_tone_blender_test.sv
